/* hw/rtl/lir_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the resampler.
package lir_pkg;

    localparam int LIR_CH      = 8;
    localparam int MAX_OUT     = 32;
    localparam int SAMPLE_W    = 24;
    localparam int WORD_W      = 32;
    localparam int STEP_W      = 22;
    localparam int CNT_W       = 4;
    localparam int K_W         = 6;
    localparam int CH_W        = 3;
    localparam int CFG_IDX_W   = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_CNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd4;

    // output word formats
    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_PCM32 = 2'd1;
    localparam logic [1:0] FMT_F32   = 2'd2;

    typedef struct packed {
        logic            load;
        logic            clr_buf;
        logic            mul;
        logic            sum;
        logic            nrm1;
        logic            nrm2;
        logic            pack;
        logic            emit;
        logic            end_frame;
        logic            bypass;
        logic            last;
        logic [CH_W-1:0] ch;
    } t_lir_cmd;

    typedef struct packed {
        logic phase_lt_one;
        logic next_lt_one;
        logic out_free;
    } t_lir_sts;

endpackage

/* hw/rtl/linear_interp_resampler_pcm_out.sv */
// Linear-interpolation resampler: takes one source frame of up to eight Q4.20 channels per
// input word and returns output frames as PCM16, PCM32 or float32 bit patterns. Samples
// are clamped to [-1,1]; channels past the source count read as zero and output channels
// past the destination count are zero. In bypass each input gives one output frame; in
// resample mode an input gives one output per Q7.16 phase below 1.0 (at most 32), each
// interpolated from the previous and current frame, last_of_run marking the final one.
// One sequencer drives a single shared multiply / normalize / pack datapath, one channel
// at a time, each channel passing through multiply, sum, coarse normalize, fine normalize
// and pack. A finished frame is loaded into the output register only when that register
// is free, so a stall on the output side holds the sequencer. The input is not taken
// again until the frame is finished, but a finished output word may sit in the output
// register while the next input is accepted.
// Config writes are always ready and must only be issued while the block is idle.
module linear_interp_resampler_pcm_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input frame channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch0,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch1,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch2,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch3,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch4,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch5,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch6,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   i_sample_ch7,
    // output frame channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch0,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch1,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch2,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch3,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch4,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch5,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch6,
    output logic signed [lir_pkg::WORD_W-1:0]     o_out_ch7,
    output logic                                  o_last_of_run,
    // config write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lir_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lir_pkg::STEP_W-1:0]            i_cfg_data
);
    import lir_pkg::*;

    logic [CNT_W-1:0]    r_src_cnt, r_dst_cnt;
    logic [1:0]          r_fmt;
    logic                r_res_en;
    logic [STEP_W-1:0]   r_step;

    logic [CNT_W-1:0]    w_srcn, w_dstn;
    logic [SAMPLE_W-1:0] w_sample [LIR_CH];
    logic [WORD_W-1:0]   w_word   [LIR_CH];
    t_lir_cmd            w_cmd;
    t_lir_sts            w_sts;

    // config registers; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt <= 4'd2;
            r_dst_cnt <= 4'd2;
            r_fmt     <= FMT_F32;
            r_res_en  <= 1'b0;
            r_step    <= 22'h10000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC_CNT: r_src_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_DST_CNT: r_dst_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_FORMAT:  r_fmt     <= i_cfg_data[1:0];
                CFG_RES_EN:  r_res_en  <= i_cfg_data[0];
                CFG_STEP:    r_step    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // effective channel counts: saturate at eight, dst of zero follows src
    assign w_srcn = (r_src_cnt > CNT_W'(LIR_CH)) ? CNT_W'(LIR_CH) : r_src_cnt;
    assign w_dstn = (r_dst_cnt == '0) ? w_srcn
                  : ((r_dst_cnt > CNT_W'(LIR_CH)) ? CNT_W'(LIR_CH) : r_dst_cnt);

    assign w_sample[0] = i_sample_ch0;
    assign w_sample[1] = i_sample_ch1;
    assign w_sample[2] = i_sample_ch2;
    assign w_sample[3] = i_sample_ch3;
    assign w_sample[4] = i_sample_ch4;
    assign w_sample[5] = i_sample_ch5;
    assign w_sample[6] = i_sample_ch6;
    assign w_sample[7] = i_sample_ch7;

    lir_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_res_en (r_res_en),
        .i_dstn   (w_dstn),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    lir_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_srcn   (w_srcn),
        .i_fmt    (r_fmt),
        .i_step   (r_step),
        .i_sample (w_sample),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_word   (w_word),
        .o_last   (o_last_of_run)
    );

    assign o_out_ch0 = w_word[0];
    assign o_out_ch1 = w_word[1];
    assign o_out_ch2 = w_word[2];
    assign o_out_ch3 = w_word[3];
    assign o_out_ch4 = w_word[4];
    assign o_out_ch5 = w_word[5];
    assign o_out_ch6 = w_word[6];
    assign o_out_ch7 = w_word[7];

`ifndef SYNTHESIS
    // an accepted frame takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer still idle after accepting a frame");

    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("output register overwritten");

    // pack always follows the fine normalize step
    a_pack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pack |-> $past(w_cmd.nrm2))
        else $error("pack without normalize");
`endif

endmodule

/* hw/rtl/lir_ctrl.sv */
// Sequencer: walks frames, output phases and channels, issuing datapath commands.
module lir_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_res_en,
    input  logic [lir_pkg::CNT_W-1:0]   i_dstn,
    input  lir_pkg::t_lir_sts           i_sts,
    output lir_pkg::t_lir_cmd           o_cmd
);
    import lir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MUL, S_SUM, S_NRM1, S_NRM2, S_PACK, S_EMIT, S_END
    } t_state;

    t_state           r_state;
    logic [K_W-1:0]   r_k;
    logic [CH_W-1:0]  r_ch;
    logic             r_byp;
    logic             w_run;

    // another output phase is due in this frame
    assign w_run = r_byp || ((r_k < K_W'(MAX_OUT)) && i_sts.phase_lt_one);

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.clr_buf   = (r_state == S_CHK);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.nrm1      = (r_state == S_NRM1);
        o_cmd.nrm2      = (r_state == S_NRM2);
        o_cmd.pack      = (r_state == S_PACK);
        o_cmd.emit      = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.end_frame = (r_state == S_END);
        o_cmd.bypass    = r_byp;
        o_cmd.last      = r_byp || (r_k == K_W'(MAX_OUT - 1)) || !i_sts.next_lt_one;
        o_cmd.ch        = r_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ch    <= '0;
            r_byp   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_k     <= '0;
                        r_byp   <= !i_res_en;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ch <= '0;
                    if (w_run) begin
                        r_state <= (i_dstn == '0) ? S_EMIT : S_MUL;
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_NRM1;
                S_NRM1: r_state <= S_NRM2;
                S_NRM2: r_state <= S_PACK;
                S_PACK: begin
                    if (({1'b0, r_ch} + 4'd1) == i_dstn) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_ch    <= r_ch + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_k     <= r_k + K_W'(1);
                        r_state <= r_byp ? S_IDLE : S_CHK;
                    end
                end
                S_END:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lir_dp.sv */
// Datapath: frame and phase state, interpolation multiply, format conversion, output register.
module lir_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lir_pkg::t_lir_cmd                  i_cmd,
    output lir_pkg::t_lir_sts                  o_sts,
    input  logic [lir_pkg::CNT_W-1:0]          i_srcn,
    input  logic [1:0]                         i_fmt,
    input  logic [lir_pkg::STEP_W-1:0]         i_step,
    input  logic [lir_pkg::SAMPLE_W-1:0]       i_sample [lir_pkg::LIR_CH],
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic [lir_pkg::WORD_W-1:0]         o_word [lir_pkg::LIR_CH],
    output logic                               o_last
);
    import lir_pkg::*;

    localparam logic [22:0] PH_ONE = 23'h10000;

    function automatic logic signed [21:0] clamp(input logic [SAMPLE_W-1:0] s);
        logic signed [23:0] x;
        x = $signed(s);
        if (x > 24'sd1048576)       clamp = 22'sd1048576;
        else if (x < -24'sd1048576) clamp = -22'sd1048576;
        else                        clamp = x[21:0];
    endfunction

    logic signed [21:0]  r_cur  [LIR_CH];
    logic signed [21:0]  r_prev [LIR_CH];
    logic [WORD_W-1:0]   r_buf  [LIR_CH];
    logic [WORD_W-1:0]   r_out  [LIR_CH];
    logic [22:0]         r_phase;
    logic signed [39:0]  r_p0, r_p1;
    logic                r_neg;
    logic [36:0]         r_q;
    logic [39:0]         r_n1, r_n2;
    logic [5:0]          r_lz1, r_lz;
    logic                r_last, r_out_valid;

    logic [16:0]         w_f, w_g;
    logic signed [39:0]  w_p0, w_p1, w_y;
    logic [39:0]         w_q40;
    logic [2:0]          w_grp, w_j, w_sh;
    logic [5:0]          w_lz1;
    logic [23:0]         w_sum_nx;
    logic [23:0]         w_mant;
    logic                w_up;
    logic [24:0]         w_m25;
    logic [7:0]          w_exp;
    logic [22:0]         w_frac;
    logic [WORD_W-1:0]   w_f32, w_pcm16, w_pcm32, w_word;
    logic [51:0]         w_m16;
    logic [15:0]         w_t16;
    logic [31:0]         w_t32;
    logic                w_rcmp;

    // interpolation weights; bypass uses the current frame alone
    assign w_f  = i_cmd.bypass ? 17'h10000 : {1'b0, r_phase[15:0]};
    assign w_g  = 17'h10000 - w_f;
    assign w_p0 = 40'(r_prev[i_cmd.ch]) * $signed({23'b0, w_g});
    assign w_p1 = 40'(r_cur[i_cmd.ch])  * $signed({23'b0, w_f});
    assign w_y  = r_p0 + r_p1;

    // coarse leading-one search by byte
    assign w_q40 = {3'b0, r_q};
    always_comb begin
        w_grp = '0;
        for (int i = 0; i < 5; i++) begin
            if (w_q40[8*i +: 8] != '0) w_grp = 3'(i);
        end
    end
    assign w_lz1 = {3'd4 - w_grp, 3'b000};

    // fine search inside the top byte
    always_comb begin
        w_j = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_n1[32 + i]) w_j = 3'(i);
        end
    end
    assign w_sh = 3'd7 - w_j;

    // float32: 24-bit mantissa, round to nearest even
    assign w_mant = r_n2[39:16];
    assign w_up   = r_n2[15] && ((|r_n2[14:0]) || w_mant[0]);
    assign w_m25  = {1'b0, w_mant} + 25'(w_up);
    assign w_exp  = 8'd130 - {2'b0, r_lz} + 8'(w_m25[24]);
    assign w_frac = w_m25[24] ? w_m25[23:1] : w_m25[22:0];
    assign w_f32  = (r_q == '0) ? '0 : {r_neg, w_exp, w_frac};

    // PCM16: q*32767 >> 36, toward zero
    assign w_m16   = {r_q, 15'b0} - {15'b0, r_q};
    assign w_t16   = w_m16[51:36];
    assign w_pcm16 = r_neg ? (32'd0 - {16'b0, w_t16}) : {16'b0, w_t16};

    // PCM32: q*(2^31-1) >> 36, toward zero
    assign w_rcmp  = {1'b0, r_q[4:0], 31'b0} < r_q;
    assign w_t32   = r_q[36:5] - 32'(w_rcmp);
    assign w_pcm32 = r_neg ? (32'd0 - w_t32) : w_t32;

    always_comb begin
        unique case (i_fmt)
            FMT_PCM16: w_word = w_pcm16;
            FMT_PCM32: w_word = w_pcm32;
            FMT_F32:   w_word = w_f32;
            default:   w_word = '0;
        endcase
    end

    assign w_sum_nx = {1'b0, r_phase} + {2'b0, i_step};

    assign o_sts.phase_lt_one = r_phase < PH_ONE;
    assign o_sts.next_lt_one  = w_sum_nx < {1'b0, PH_ONE};
    assign o_sts.out_free     = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < LIR_CH; c++) r_prev[c] <= '0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (!i_cmd.bypass) r_phase <= w_sum_nx[22:0];
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.end_frame) begin
                r_phase <= (r_phase >= PH_ONE) ? {1'b0, 22'(r_phase - PH_ONE)} : '0;
                for (int c = 0; c < LIR_CH; c++) r_prev[c] <= r_cur[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int c = 0; c < LIR_CH; c++) begin
                r_cur[c] <= (CNT_W'(c) < i_srcn) ? clamp(i_sample[c]) : '0;
            end
        end
        if (i_cmd.clr_buf) begin
            for (int c = 0; c < LIR_CH; c++) r_buf[c] <= '0;
        end
        if (i_cmd.mul) begin
            r_p0 <= w_p0;
            r_p1 <= w_p1;
        end
        if (i_cmd.sum) begin
            r_neg <= w_y[39];
            r_q   <= w_y[39] ? 37'(-w_y) : w_y[36:0];
        end
        if (i_cmd.nrm1) begin
            r_n1  <= w_q40 << w_lz1;
            r_lz1 <= w_lz1;
        end
        if (i_cmd.nrm2) begin
            r_n2 <= r_n1 << w_sh;
            r_lz <= r_lz1 + {3'b0, w_sh};
        end
        if (i_cmd.pack) r_buf[i_cmd.ch] <= w_word;
        if (i_cmd.emit) begin
            r_out  <= r_buf;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;
    assign o_last  = r_last;

endmodule
